FILE: rtl/bei_pkg.sv
// shared constants for the box edge intersection block
`timescale 1ns / 1ps
package bei_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned SIZE_BITS = 15;
  localparam int unsigned CNT_BITS = 8;
  localparam logic CMD_PLAIN = 1'b0;
  localparam logic CMD_DIST = 1'b1;
  localparam logic [1:0] HINT_SLOPE = 2'd0;
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_HORZ = 2'd1;
  localparam logic [1:0] SIDE_VERT = 2'd2;
endpackage

FILE: rtl/bei_core.sv
// pipelined datapath: difference, products, restoring divider, final add
`timescale 1ns / 1ps
module bei_core #(
  parameter int unsigned COORD_BITS = bei_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_ok,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] from_x,
  input  logic signed [COORD_BITS-1:0] from_y,
  input  logic signed [COORD_BITS-1:0] to_x,
  input  logic signed [COORD_BITS-1:0] to_y,
  input  logic [bei_pkg::SIZE_BITS-1:0] box_width,
  input  logic [bei_pkg::SIZE_BITS-1:0] box_height,
  input  logic [bei_pkg::CNT_BITS-1:0]  line_order,
  input  logic [bei_pkg::CNT_BITS-1:0]  line_count,
  input  logic [1:0]                    side_hint,
  output logic                          v_out,
  output logic signed [COORD_BITS:0]    rx_out,
  output logic signed [COORD_BITS:0]    ry_out,
  output logic [1:0]                    side_out
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DB = CB + 1;             // |difference| width
  localparam int unsigned SB = bei_pkg::SIZE_BITS;
  localparam int unsigned NB = bei_pkg::CNT_BITS;
  localparam int unsigned PB = DB + SB;            // product width
  localparam int unsigned DVB = (DB > NB + 1) ? DB : NB + 1; // divisor width
  localparam int unsigned QB = (DB > SB) ? DB : SB;          // quotient width
  localparam int unsigned NS = QB;                 // divider stages

  // stage 1: differences and clamps
  logic v1_r;
  logic cmd1_r, rt1_r, dn1_r, vert1_r;
  logic signed [CB-1:0] x1_r, y1_r;
  logic [DB-1:0] dx1_r, dy1_r;
  logic [SB-1:0] w1_r, h1_r;
  logic [NB-1:0] o1_r, n1_r;
  logic [1:0] hint1_r;

  logic signed [DB-1:0] ddx, ddy;
  logic [NB-1:0] n_c, o_c;
  always_comb begin
    ddx = DB'(to_x) - DB'(from_x);
    ddy = DB'(to_y) - DB'(from_y);
    n_c = (line_count == '0) ? NB'(1) : line_count;
    o_c = (line_order == '0) ? NB'(1) : line_order;
    if (o_c > n_c) o_c = n_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ok;
    end
    if (adv) begin
      cmd1_r <= cmd;
      x1_r <= from_x;
      y1_r <= from_y;
      rt1_r <= from_x < to_x;
      dn1_r <= from_y < to_y;
      dx1_r <= ddx[DB-1] ? DB'(-ddx) : DB'(ddx);
      dy1_r <= ddy[DB-1] ? DB'(-ddy) : DB'(ddy);
      w1_r <= box_width;
      h1_r <= box_height;
      o1_r <= o_c;
      n1_r <= n_c;
      hint1_r <= side_hint;
      vert1_r <= side_hint >= 2'd2;
    end
  end

  // stage 2: products and case selection
  logic v2_r, rt2_r, dn2_r;
  logic signed [CB-1:0] x2_r, y2_r;
  logic [SB-2:0] a2_r, b2_r;
  logic [1:0] side2_r;
  logic [1:0] mode2_r; // 0 fixed, 1 vertical side with quotient on y, 2 horizontal with x
  logic [PB+NB:0] num2_r;
  logic [DVB-1:0] den2_r;

  logic [PB-1:0] p_dyw, p_hdx;
  logic [SB+NB:0] sp_w, sp_h;
  logic [SB-2:0] a1, b1;
  logic vsel;
  always_comb begin
    a1 = w1_r[SB-1:1];
    b1 = h1_r[SB-1:1];
    p_dyw = PB'(dy1_r) * PB'(w1_r);
    p_hdx = PB'(h1_r) * PB'(dx1_r);
    sp_w = (SB+NB+1)'(w1_r) * (SB+NB+1)'({o1_r, 1'b0} - (NB+1)'(1));
    sp_h = (SB+NB+1)'(h1_r) * (SB+NB+1)'({o1_r, 1'b0} - (NB+1)'(1));
    if (hint1_r == bei_pkg::HINT_SLOPE) vsel = (dx1_r != '0) && (dy1_r < dx1_r);
    else vsel = vert1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      x2_r <= x1_r;
      y2_r <= y1_r;
      rt2_r <= rt1_r;
      dn2_r <= dn1_r;
      a2_r <= a1;
      b2_r <= b1;
      if (cmd1_r == bei_pkg::CMD_PLAIN) begin
        side2_r <= bei_pkg::SIDE_NONE;
        if (dx1_r == '0) begin
          mode2_r <= 2'd0;
          num2_r <= '0;
          den2_r <= DVB'(1);
        end else if (dy1_r == '0) begin
          // vertical side with zero offset
          mode2_r <= 2'd1;
          num2_r <= '0;
          den2_r <= DVB'(1);
        end else if (p_dyw < p_hdx) begin
          mode2_r <= 2'd1;
          num2_r <= (PB+NB+1)'((PB)'(a1) * PB'(dy1_r));
          den2_r <= DVB'(dx1_r);
        end else begin
          mode2_r <= 2'd2;
          num2_r <= (PB+NB+1)'((PB)'(b1) * PB'(dx1_r));
          den2_r <= DVB'(dy1_r);
        end
      end else begin
        den2_r <= DVB'({n1_r, 1'b0});
        if (vsel) begin
          side2_r <= bei_pkg::SIDE_VERT;
          mode2_r <= 2'd1;
          num2_r <= (PB+NB+1)'(sp_h) + (PB+NB+1)'(n1_r);
        end else begin
          side2_r <= bei_pkg::SIDE_HORZ;
          mode2_r <= 2'd2;
          num2_r <= (PB+NB+1)'(sp_w) + (PB+NB+1)'(n1_r);
        end
      end
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  logic [NS:0] dv_r;
  logic [PB+NB:0] rem_r [NS+1];
  logic [DVB-1:0] den_r [NS+1];
  logic [QB-1:0] q_r [NS+1];
  logic signed [CB-1:0] dx_r [NS+1], dy_r [NS+1];
  logic [SB-2:0] da_r [NS+1], db_r [NS+1];
  logic [1:0] dm_r [NS+1], ds_r [NS+1];
  logic [NS:0] drt_r, ddn_r;

  always_comb begin
    dv_r[0] = v2_r;
    rem_r[0] = num2_r;
    den_r[0] = den2_r;
    q_r[0] = '0;
    dx_r[0] = x2_r;
    dy_r[0] = y2_r;
    da_r[0] = a2_r;
    db_r[0] = b2_r;
    dm_r[0] = mode2_r;
    ds_r[0] = side2_r;
    drt_r[0] = rt2_r;
    ddn_r[0] = dn2_r;
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int unsigned SH = NS - 1 - k;
    logic [PB+NB+QB:0] trial;
    logic ge;
    always_comb begin
      trial = (PB+NB+QB+1)'(den_r[k]) << SH;
      ge = (PB+NB+QB+1)'(rem_r[k]) >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
      if (adv) begin
        rem_r[k+1] <= ge ? (PB+NB+1)'((PB+NB+QB+1)'(rem_r[k]) - trial) : rem_r[k];
        q_r[k+1] <= q_r[k] | (ge ? (QB'(1) << SH) : '0);
        den_r[k+1] <= den_r[k];
        dx_r[k+1] <= dx_r[k];
        dy_r[k+1] <= dy_r[k];
        da_r[k+1] <= da_r[k];
        db_r[k+1] <= db_r[k];
        dm_r[k+1] <= dm_r[k];
        ds_r[k+1] <= ds_r[k];
        drt_r[k+1] <= drt_r[k];
        ddn_r[k+1] <= ddn_r[k];
      end
    end
  end

  // final stage: offsets and sums
  logic signed [DB-1:0] xe, ye, ae, be, qe, hx, hy, dstx, dsty;
  logic [1:0] sd;
  always_comb begin
    xe = DB'(dx_r[NS]);
    ye = DB'(dy_r[NS]);
    ae = DB'(da_r[NS]);
    be = DB'(db_r[NS]);
    qe = DB'(q_r[NS]);
    sd = ds_r[NS];
    hx = drt_r[NS] ? xe + ae : xe - ae;
    hy = ddn_r[NS] ? ye + be : ye - be;
    if (sd == bei_pkg::SIDE_NONE) begin
      if (dm_r[NS] == 2'd1) begin
        dstx = hx;
        dsty = ddn_r[NS] ? ye + qe : ye - qe;
      end else if (dm_r[NS] == 2'd2) begin
        dstx = drt_r[NS] ? xe + qe : xe - qe;
        dsty = hy;
      end else begin
        dstx = xe;
        dsty = hy;
      end
    end else if (sd == bei_pkg::SIDE_VERT) begin
      dstx = hx;
      dsty = ye - be + qe;
    end else begin
      dstx = xe - ae + qe;
      dsty = hy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= dv_r[NS];
    end
    if (adv) begin
      rx_out <= dstx;
      ry_out <= dsty;
      side_out <= sd;
    end
  end
endmodule

FILE: rtl/box_edge_intersection.sv
// top level of the box edge intersection block
// pipeline: three fixed stages plus one divider stage per quotient bit, COORD_BITS+1
// or SIZE_BITS if larger; throughput: one transfer per cycle while results are taken
// the pipeline stalls as a whole when the output register holds a result not taken
// reset: synchronous active low, clears all valid bits; no clearing pass
`timescale 1ns / 1ps
module box_edge_intersection #(
  parameter int unsigned COORD_BITS = bei_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [COORD_BITS-1:0]  in_from_x,
  input  logic signed [COORD_BITS-1:0]  in_from_y,
  input  logic signed [COORD_BITS-1:0]  in_to_x,
  input  logic signed [COORD_BITS-1:0]  in_to_y,
  input  logic [bei_pkg::SIZE_BITS-1:0] in_box_width,
  input  logic [bei_pkg::SIZE_BITS-1:0] in_box_height,
  input  logic [bei_pkg::CNT_BITS-1:0]  in_line_order,
  input  logic [bei_pkg::CNT_BITS-1:0]  in_line_count,
  input  logic [1:0]                    in_side_hint,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS:0]    out_cross_x,
  output logic signed [COORD_BITS:0]    out_cross_y,
  output logic [1:0]                    out_side_used
);
  logic adv;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  bei_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_ok      (in_valid),
    .cmd        (in_cmd),
    .from_x     (in_from_x),
    .from_y     (in_from_y),
    .to_x       (in_to_x),
    .to_y       (in_to_y),
    .box_width  (in_box_width),
    .box_height (in_box_height),
    .line_order (in_line_order),
    .line_count (in_line_count),
    .side_hint  (in_side_hint),
    .v_out      (out_valid),
    .rx_out     (out_cross_x),
    .ry_out     (out_cross_y),
    .side_out   (out_side_used)
  );
endmodule

FILE: rtl/bei_checker.sv
// port-level checker for the box edge intersection block, with its bind
`timescale 1ns / 1ps
module bei_checker #(
  parameter int unsigned COORD_BITS = bei_pkg::COORD_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [COORD_BITS:0] out_cross_x,
  input logic [1:0]                 out_side_used
);
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready) else $error("no input on output transfer");
  a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_side_used != 2'd3)) else $error("bad side");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_cross_x) && out_valid))
    else $error("stalled result changed");
endmodule

bind box_edge_intersection bei_checker #(.COORD_BITS(COORD_BITS)) u_bei_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_cross_x   (out_cross_x),
  .out_side_used (out_side_used)
);

FILE: bench/box_edge_intersection_tb.sv
// self-checking testbench for the box edge intersection block
`timescale 1ns / 1ps
module box_edge_intersection_tb;
  localparam int CB = bei_pkg::COORD_BITS_DEF;
  localparam int SB = bei_pkg::SIZE_BITS;
  localparam int NB = bei_pkg::CNT_BITS;
  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 700;
  localparam int N_DIRECTED = 16;

  typedef struct packed {
    logic                 cmd;
    logic signed [CB-1:0] fx;
    logic signed [CB-1:0] fy;
    logic signed [CB-1:0] tx;
    logic signed [CB-1:0] ty;
    logic [SB-1:0]        w;
    logic [SB-1:0]        h;
    logic [NB-1:0]        ord;
    logic [NB-1:0]        cnt;
    logic [1:0]           hint;
  } query_t;

  typedef struct packed {
    logic [CB:0] x;
    logic [CB:0] y;
    logic [1:0]  side;
  } cross_t;

  typedef struct {
    query_t q;
    logic   has_exp;
    cross_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  query_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CB:0] out_cross_x;
  logic signed [CB:0] out_cross_y;
  logic [1:0] out_side_used;

  cross_t crossings_due[$];
  int errors = 0;
  bit sent_all = 1'b0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  box_edge_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(cur.cmd), .in_from_x(cur.fx), .in_from_y(cur.fy),
    .in_to_x(cur.tx), .in_to_y(cur.ty),
    .in_box_width(cur.w), .in_box_height(cur.h),
    .in_line_order(cur.ord), .in_line_count(cur.cnt), .in_side_hint(cur.hint),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
    .out_side_used(out_side_used)
  );

  function automatic cross_t edge_crossing(query_t q);
    longint x, y, tx, ty, w, h, o, n, a, b, dx, dy, rx, ry, off;
    bit right, down, vert;
    cross_t r;
    x = q.fx; y = q.fy; tx = q.tx; ty = q.ty;
    w = q.w; h = q.h; o = q.ord; n = q.cnt;
    a = w / 2; b = h / 2;
    dx = (tx > x) ? tx - x : x - tx;
    dy = (ty > y) ? ty - y : y - ty;
    right = x < tx; down = y < ty;
    r.side = bei_pkg::SIDE_NONE;
    if (q.cmd == bei_pkg::CMD_PLAIN) begin
      if (dx == 0) begin
        rx = x; ry = down ? y + b : y - b;
      end else if (dy == 0) begin
        rx = right ? x + a : x - a; ry = y;
      end else if (dy * w < h * dx) begin
        off = (a * dy) / dx;
        rx = right ? x + a : x - a; ry = down ? y + off : y - off;
      end else begin
        off = (b * dx) / dy;
        rx = right ? x + off : x - off; ry = down ? y + b : y - b;
      end
    end else begin
      if (n < 1) n = 1;
      if (o < 1) o = 1;
      if (o > n) o = n;
      if (q.hint == bei_pkg::HINT_SLOPE) vert = (dx != 0) && (dy < dx);
      else vert = q.hint >= bei_pkg::SIDE_VERT;
      if (vert) begin
        rx = right ? x + a : x - a;
        ry = (y - b) + (h * (2 * o - 1) + n) / (2 * n);
        r.side = bei_pkg::SIDE_VERT;
      end else begin
        rx = (x - a) + (w * (2 * o - 1) + n) / (2 * n);
        ry = down ? y + b : y - b;
        r.side = bei_pkg::SIDE_HORZ;
      end
    end
    r.x = rx[CB:0];
    r.y = ry[CB:0];
    return r;
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.cmd = 1'($urandom_range(0, 1));
    q.fx = CB'($urandom); q.fy = CB'($urandom);
    case ($urandom_range(0, 3))
      0: begin q.tx = q.fx; q.ty = CB'($urandom); end
      1: begin q.tx = CB'($urandom); q.ty = q.fy; end
      2: begin
        q.tx = CB'(q.fx + $signed(CB'($urandom_range(0, 400))) - 200);
        q.ty = CB'(q.fy + $signed(CB'($urandom_range(0, 400))) - 200);
      end
      default: begin q.tx = CB'($urandom); q.ty = CB'($urandom); end
    endcase
    q.w = ($urandom_range(0, 3) == 0) ? SB'($urandom) : SB'($urandom_range(0, 300));
    q.h = ($urandom_range(0, 3) == 0) ? SB'($urandom) : SB'($urandom_range(0, 300));
    q.cnt = ($urandom_range(0, 3) == 0) ? NB'($urandom) : NB'($urandom_range(0, 8));
    q.ord = ($urandom_range(0, 3) == 0) ? NB'($urandom) : NB'($urandom_range(0, 9));
    q.hint = 2'($urandom_range(0, 3));
    return q;
  endfunction

  task automatic send_query(query_t q, cross_t e);
    int gap;
    gap = $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cur <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    crossings_due.push_back(e);
  endtask

  row_t directed [N_DIRECTED];

  initial begin
    row_t r;
    directed = '{
      '{'{bei_pkg::CMD_PLAIN, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 15'd10, 15'd20,
          8'd1, 8'd1, 2'd0},
        1'b1, '{17'd0, 17'd10, bei_pkg::SIDE_NONE}},
      '{'{bei_pkg::CMD_PLAIN, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd10, 15'd20,
          8'd1, 8'd1, 2'd0},
        1'b1, '{17'd0, 17'h1fff6, bei_pkg::SIDE_NONE}},
      '{'{bei_pkg::CMD_PLAIN, 16'sd0, 16'sd0, 16'sd9, 16'sd0, 15'd10, 15'd20,
          8'd1, 8'd1, 2'd0},
        1'b1, '{17'd5, 17'd0, bei_pkg::SIDE_NONE}},
      '{'{bei_pkg::CMD_PLAIN, 16'sd0, 16'sd0, -16'sd9, 16'sd3, 15'd10, 15'd20,
          8'd0, 8'd0, 2'd3},
        1'b0, '0},
      '{'{bei_pkg::CMD_PLAIN, 16'sd5, -16'sd5, 16'sd6, 16'sd90, 15'd10, 15'd20,
          8'd0, 8'd0, 2'd0},
        1'b0, '0},
      '{'{bei_pkg::CMD_PLAIN, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff,
          8'd255, 8'd255, 2'd0},
        1'b0, '0},
      '{'{bei_pkg::CMD_PLAIN, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h7fff, 15'd1,
          8'd1, 8'd1, 2'd0},
        1'b0, '0},
      '{'{bei_pkg::CMD_PLAIN, 16'h7fff, 16'h8000, 16'h7ffe, 16'h7fff, 15'd0, 15'd0,
          8'd1, 8'd1, 2'd0},
        1'b0, '0},
      '{'{bei_pkg::CMD_DIST, 16'sd0, 16'sd0, 16'sd9, 16'sd1, 15'd10, 15'd20,
          8'd1, 8'd1, 2'd0},
        1'b1, '{17'd5, 17'd0, bei_pkg::SIDE_VERT}},
      '{'{bei_pkg::CMD_DIST, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd10, 15'd20,
          8'd1, 8'd1, 2'd0},
        1'b1, '{17'd0, 17'h1fff6, bei_pkg::SIDE_HORZ}},
      '{'{bei_pkg::CMD_DIST, 16'sd0, 16'sd0, 16'sd3, 16'sd3, 15'd10, 15'd20,
          8'd9, 8'd2, 2'd1},
        1'b0, '0},
      '{'{bei_pkg::CMD_DIST, 16'sd0, 16'sd0, 16'sd3, 16'sd30, 15'd10, 15'd20,
          8'd0, 8'd0, 2'd2},
        1'b0, '0},
      '{'{bei_pkg::CMD_DIST, 16'sd0, 16'sd0, -16'sd3, 16'sd30, 15'd10, 15'd20,
          8'd2, 8'd3, 2'd3},
        1'b0, '0},
      '{'{bei_pkg::CMD_DIST, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 15'h7fff, 15'h7fff,
          8'd255, 8'd255, 2'd0},
        1'b0, '0},
      '{'{bei_pkg::CMD_DIST, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff,
          8'd1, 8'd255, 2'd0},
        1'b0, '0},
      '{'{bei_pkg::CMD_DIST, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 15'd0, 15'd0,
          8'd200, 8'd100, 2'd0},
        1'b0, '0}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      r = directed[i];
      send_query(r.q, r.has_exp ? r.exp : edge_crossing(r.q));
    end
    repeat (N_RANDOM) begin
      r.q = random_query();
      send_query(r.q, edge_crossing(r.q));
    end
    in_valid <= 1'b0;
    sent_all = 1'b1;
  end

  // result side: random wait before each transfer
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (crossings_due.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          cross_t e;
          e = crossings_due.pop_front();
          if (out_cross_x !== e.x) begin
            $error("cross_x exp %0d got %0d", $signed(e.x), out_cross_x); errors++;
          end
          if (out_cross_y !== e.y) begin
            $error("cross_y exp %0d got %0d", $signed(e.y), out_cross_y); errors++;
          end
          if (out_side_used !== e.side) begin
            $error("side_used exp %0d got %0d", e.side, out_side_used); errors++;
          end
        end
      end
      if (!rst_n) begin
        hold = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        if (out_valid && out_ready) hold = $urandom_range(0, 18);
        else if (hold > 0) hold--;
        out_ready <= (hold == 0);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (sent_all && crossings_due.size() == 0) begin
        repeat (40) @(posedge clk);
        if (errors == 0 && !out_valid)
          $display("box_edge_intersection regression: pass");
        else
          $display("box_edge_intersection regression: fail");
        $finish;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("box_edge_intersection regression: fail");
        $finish;
      end
    end
  end
endmodule
